/* rtl/smt_pkg.sv */
// Shared constants, codes and types of the sorted multiset table.
package smt_pkg;

  localparam int unsigned CAPACITY_DEF = 16;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_SEARCH = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

/* rtl/smt_cmp.sv */
// Shared signed comparator used by the table scan.
module smt_cmp (
  input  logic signed [smt_pkg::VALUE_W-1:0] entry_i,
  input  logic signed [smt_pkg::VALUE_W-1:0] key_i,
  output smt_pkg::cmp_res_t                  res_o
);
  import smt_pkg::*;

  always_comb begin
    res_o.lt = entry_i < key_i;
    res_o.eq = entry_i == key_i;
  end

endmodule

/* rtl/sorted_multiset_table.sv */
// Top level of the sorted multiset table with its sequencer and entry memory.
//
// The block holds up to Capacity signed 32-bit entries in ascending order,
// duplicates allowed, in a single-port-write memory with one registered read
// port. Each item runs alone: a scan reads one entry at a time, in a read
// state and then a compare state, through the single comparator until it
// finds the first entry that is not smaller than the value, then an insert
// or delete moves each later entry by one place over the same read port.
// An item also passes the end-of-table check, the decision, the write of an
// inserted value and the result stage, and in_ready_o is low until its
// result is registered.
// The memory needs no clearing after reset.
module sorted_multiset_table #(
  parameter int unsigned Capacity = smt_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [smt_pkg::ACTION_W-1:0]        action_i,
  input  logic signed [smt_pkg::VALUE_W-1:0]  value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                success_o,
  output logic [smt_pkg::STATUS_W-1:0]        status_o,
  output logic [smt_pkg::COUNT_W-1:0]         entry_count_o
);
  import smt_pkg::*;

  localparam int unsigned AW = (Capacity > 1) ? $clog2(Capacity) : 1;
  localparam int unsigned CW = $clog2(Capacity + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FIN
  } state_e;

  state_e                    state_q;
  logic [ACTION_W-1:0]       act_q;
  logic signed [VALUE_W-1:0] val_q;
  logic [CW-1:0]             cnt_q;
  logic [CW-1:0]             idx_q;
  logic [CW-1:0]             pos_q;
  logic                      found_q;
  logic                      res_ok_q;
  logic [STATUS_W-1:0]       res_st_q;
  logic                      out_valid_q;
  logic                      success_q;
  logic [STATUS_W-1:0]       status_q;
  logic [COUNT_W-1:0]        count_out_q;

  logic signed [VALUE_W-1:0] mem_q [Capacity];
  logic signed [VALUE_W-1:0] rd_q;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic signed [VALUE_W-1:0] mem_wdata;

  cmp_res_t                  cmp;
  logic [CW-1:0]             idx_p1;
  logic [CW-1:0]             idx_m1;
  logic [CW:0]               idx_p2;
  logic [CW:0]               pos_p1;
  logic [CW:0]               cnt_x;
  logic [CW+COUNT_W-1:0]     cnt_ext;

  smt_cmp u_cmp (
    .entry_i (rd_q),
    .key_i   (val_q),
    .res_o   (cmp)
  );

  assign idx_p1  = idx_q + CW'(1);
  assign idx_m1  = idx_q - CW'(1);
  assign idx_p2  = {1'b0, idx_q} + (CW + 1)'(2);
  assign pos_p1  = {1'b0, pos_q} + (CW + 1)'(1);
  assign cnt_x   = {1'b0, cnt_q};
  assign cnt_ext = {{COUNT_W{1'b0}}, cnt_q};

  always_comb begin
    rd_addr   = idx_q[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx_q[AW-1:0];
    mem_wdata = rd_q;
    case (state_q)
      S_SHIFT_RD: begin
        rd_addr = (act_q == ACT_INSERT) ? idx_m1[AW-1:0] : idx_p1[AW-1:0];
      end
      S_SHIFT_WR: begin
        mem_we = 1'b1;
      end
      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_q[AW-1:0];
        mem_wdata = val_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      found_q     <= 1'b0;
      act_q       <= ACT_INSERT;
      val_q       <= '0;
      res_ok_q    <= 1'b0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            act_q   <= action_i;
            val_q   <= value_i;
            idx_q   <= '0;
            state_q <= S_SCAN_RD;
          end
        end
        S_SCAN_RD: begin
          if (idx_q >= cnt_q) begin
            pos_q   <= idx_q;
            found_q <= 1'b0;
            state_q <= S_DECIDE;
          end else begin
            state_q <= S_SCAN_CMP;
          end
        end
        S_SCAN_CMP: begin
          if (cmp.lt) begin
            idx_q   <= idx_p1;
            state_q <= S_SCAN_RD;
          end else begin
            pos_q   <= idx_q;
            found_q <= cmp.eq;
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          case (act_q)
            ACT_INSERT: begin
              if (cnt_q == CW'(Capacity)) begin
                res_ok_q <= 1'b0;
                res_st_q <= ST_FULL;
                state_q  <= S_FIN;
              end else begin
                idx_q   <= cnt_q;
                state_q <= (cnt_q > pos_q) ? S_SHIFT_RD : S_PUT;
              end
            end
            ACT_SEARCH: begin
              res_ok_q <= found_q;
              res_st_q <= found_q ? ST_OK : ST_ABSENT;
              state_q  <= S_FIN;
            end
            ACT_DELETE: begin
              if (!found_q) begin
                res_ok_q <= 1'b0;
                res_st_q <= ST_ABSENT;
                state_q  <= S_FIN;
              end else if (pos_p1 < cnt_x) begin
                idx_q   <= pos_q;
                state_q <= S_SHIFT_RD;
              end else begin
                cnt_q    <= cnt_q - CW'(1);
                res_ok_q <= 1'b1;
                res_st_q <= ST_OK;
                state_q  <= S_FIN;
              end
            end
            default: begin
              res_ok_q <= 1'b0;
              res_st_q <= ST_OK;
              state_q  <= S_FIN;
            end
          endcase
        end
        S_SHIFT_RD: begin
          state_q <= S_SHIFT_WR;
        end
        S_SHIFT_WR: begin
          if (act_q == ACT_INSERT) begin
            idx_q   <= idx_m1;
            state_q <= (idx_m1 > pos_q) ? S_SHIFT_RD : S_PUT;
          end else begin
            idx_q <= idx_p1;
            if (idx_p2 < cnt_x) begin
              state_q <= S_SHIFT_RD;
            end else begin
              cnt_q    <= cnt_q - CW'(1);
              res_ok_q <= 1'b1;
              res_st_q <= ST_OK;
              state_q  <= S_FIN;
            end
          end
        end
        S_PUT: begin
          cnt_q    <= cnt_q + CW'(1);
          res_ok_q <= 1'b1;
          res_st_q <= ST_OK;
          state_q  <= S_FIN;
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && (!out_valid_q || out_ready_i)) begin
      success_q   <= res_ok_q;
      status_q    <= res_st_q;
      count_out_q <= cnt_ext[COUNT_W-1:0];
    end
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign out_valid_o   = out_valid_q;
  assign success_o     = success_q;
  assign status_o      = status_q;
  assign entry_count_o = count_out_q;

endmodule

/* rtl/smt_checker.sv */
// Port-level assertions for the sorted multiset table and their binding.
module smt_checker #(
  parameter int unsigned Capacity = smt_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                in_ready_o,
  input  logic                                out_valid_o,
  input  logic                                out_ready_i,
  input  logic                                success_o,
  input  logic [smt_pkg::STATUS_W-1:0]        status_o,
  input  logic [smt_pkg::COUNT_W-1:0]         entry_count_o
);
  import smt_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1) + COUNT_W;
  localparam logic [CntW-1:0] CapFull = CntW'(Capacity);

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken again right after an item was accepted");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(success_o)
      && $stable(status_o) && $stable(entry_count_o))
    else $error("stalled result changed");

  a_success_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && success_o |-> status_o == ST_OK)
    else $error("successful result with an error status");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |->
      !success_o && entry_count_o == CapFull[COUNT_W-1:0])
    else $error("full status without a full table");

  a_bad_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o == ST_OK || status_o == ST_ABSENT || status_o == ST_FULL)
    else $error("undefined status code");

endmodule

bind sorted_multiset_table smt_checker #(.Capacity(Capacity)) u_smt_checker (.*);

/* verif/tb_sorted_multiset_table.sv */
`timescale 1ns / 100ps
// Self-checking testbench of the sorted multiset table with directed and random items.
module tb_sorted_multiset_table;
  import smt_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
  localparam int NUM_RANDOM = 600;
  localparam int CALM_ITEMS = 80;
  localparam int HOLD_AT_ITEM = 150;
  localparam int LONG_HOLD = 300;
  localparam int DRAIN_CYCLES = 4 * CAP + 20;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_OPENING = 27;

  typedef struct packed {
    logic                success;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } verdict_t;

  typedef struct packed {
    logic [ACTION_W-1:0]       act;
    logic signed [VALUE_W-1:0] val;
    logic                      typed;
    verdict_t                  verdict;
  } table_row_t;

  localparam verdict_t NO_VERDICT = '0;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic [ACTION_W-1:0]       action_i;
  logic signed [VALUE_W-1:0] value_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic                      success_o;
  logic [STATUS_W-1:0]       status_o;
  logic [COUNT_W-1:0]        entry_count_o;

  logic signed [VALUE_W-1:0] held_vals [CAP];
  int                        held_count = 0;
  verdict_t                  pending_verdicts [$];
  int                        errors = 0;
  int                        cycles = 0;
  bit                        calm = 1'b0;
  bit                        hold_off_req = 1'b0;

  table_row_t opening_rows [NUM_OPENING] = '{
    '{ACT_SEARCH, 32'sh0000_0000, 1'b1, '{1'b0, ST_ABSENT, 5'd0}},
    '{ACT_DELETE, 32'sh7fff_ffff, 1'b1, '{1'b0, ST_ABSENT, 5'd0}},
    '{ACT_UNUSED, 32'shffff_ffff, 1'b1, '{1'b0, ST_OK, 5'd0}},
    '{ACT_INSERT, 32'sh7fff_ffff, 1'b1, '{1'b1, ST_OK, 5'd1}},
    '{ACT_INSERT, 32'sh8000_0000, 1'b1, '{1'b1, ST_OK, 5'd2}},
    '{ACT_INSERT, 32'sh0000_0000, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0000, 1'b0, NO_VERDICT},
    '{ACT_SEARCH, 32'sh8000_0000, 1'b1, '{1'b1, ST_OK, 5'd4}},
    '{ACT_SEARCH, 32'sh7fff_ffff, 1'b1, '{1'b1, ST_OK, 5'd4}},
    '{ACT_DELETE, 32'sh0000_0000, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh7fff_ffff, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh8000_0000, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'shffff_ffff, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0001, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh5555_5555, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'shaaaa_aaaa, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0064, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'shffff_ff9c, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0000, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh7fff_fffe, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh8000_0001, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0000, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0005, 1'b0, NO_VERDICT},
    '{ACT_INSERT, 32'sh0000_0003, 1'b1, '{1'b0, ST_FULL, 5'd16}},
    '{ACT_UNUSED, 32'sh0000_0000, 1'b1, '{1'b0, ST_OK, 5'd16}},
    '{ACT_DELETE, 32'sh8000_0000, 1'b1, '{1'b1, ST_OK, 5'd15}},
    '{ACT_DELETE, 32'sh7fff_ffff, 1'b0, NO_VERDICT}
  };

  sorted_multiset_table #(
    .Capacity(CAP)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .action_i      (action_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .success_o     (success_o),
    .status_o      (status_o),
    .entry_count_o (entry_count_o)
  );

  always #1 clk_i = ~clk_i;

  function automatic verdict_t apply_action(input logic [ACTION_W-1:0] act,
                                            input logic signed [VALUE_W-1:0] val);
    int pos;
    int k;
    bit hit;
    verdict_t r;
    r = '{success: 1'b0, status: ST_OK, count: '0};
    pos = 0;
    while (pos < held_count && held_vals[pos] < val) pos++;
    hit = (pos < held_count) && (held_vals[pos] == val);
    case (act)
      ACT_INSERT: begin
        if (held_count >= CAP) begin
          r.status = ST_FULL;
        end else begin
          for (k = held_count; k > pos; k--) held_vals[k] = held_vals[k-1];
          held_vals[pos] = val;
          held_count++;
          r.success = 1'b1;
        end
      end
      ACT_SEARCH, ACT_DELETE: begin
        if (!hit) begin
          r.status = ST_ABSENT;
        end else begin
          r.success = 1'b1;
          if (act == ACT_DELETE) begin
            for (k = pos; k < held_count - 1; k++) held_vals[k] = held_vals[k+1];
            held_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = held_count[COUNT_W-1:0];
    return r;
  endfunction

  task automatic send_item(input logic [ACTION_W-1:0] act,
                           input logic signed [VALUE_W-1:0] val,
                           input bit typed, input verdict_t typed_v);
    verdict_t v;
    in_valid_i <= 1'b1;
    action_i   <= act;
    value_i    <= val;
    do @(posedge clk_i); while (!in_ready_o);
    v = apply_action(act, val);
    pending_verdicts.push_back(typed ? typed_v : v);
  endtask

  task automatic idle_gap(input bit bursty);
    if (!calm && bursty && $urandom_range(0, 2) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [ACTION_W-1:0]       act;
    logic signed [VALUE_W-1:0] val;
    int                        pick;
    int                        p_ins;
    bit                        fill_bias;
    bit                        tx_bursty;
    rst_ni     = 1'b0;
    in_valid_i = 1'b0;
    action_i   = '0;
    value_i    = '0;
    fill_bias  = 1'b1;
    tx_bursty  = 1'b1;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_rows[i]) begin
      send_item(opening_rows[i].act, opening_rows[i].val, opening_rows[i].typed,
                opening_rows[i].verdict);
      idle_gap(tx_bursty);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == HOLD_AT_ITEM) hold_off_req = 1'b1;
      if (n >= NUM_RANDOM - CALM_ITEMS) calm = 1'b1;
      if ($urandom_range(0, 39) == 0) fill_bias = !fill_bias;
      if ($urandom_range(0, 39) == 0) tx_bursty = !tx_bursty;

      // The insert share swings so that the table keeps running full and empty.
      p_ins = fill_bias ? 70 : 25;
      pick = $urandom_range(0, 99);
      if (pick < 3) act = ACT_UNUSED;
      else if (pick < 3 + p_ins) act = ACT_INSERT;
      else if (pick[0]) act = ACT_SEARCH;
      else act = ACT_DELETE;

      pick = $urandom_range(0, 9);
      if (pick < 4 && held_count > 0) begin
        val = held_vals[$urandom_range(0, held_count - 1)];
      end else if (pick < 7) begin
        val = int'($urandom_range(0, 15)) - 8;
      end else if (pick == 7) begin
        case ($urandom_range(0, 3))
          0: val = 32'sh8000_0000;
          1: val = 32'sh7fff_ffff;
          2: val = 32'shffff_ffff;
          default: val = 32'sh0000_0000;
        endcase
      end else begin
        val = $urandom;
      end

      send_item(act, val, 1'b0, NO_VERDICT);
      idle_gap(tx_bursty);
    end
    in_valid_i <= 1'b0;

    while (pending_verdicts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("tb_sorted_multiset_table: done, clean");
    end else begin
      $display("tb_sorted_multiset_table: done, errors");
    end
    $finish;
  end

  initial begin : receiver
    bit rx_bursty;
    rx_bursty   = 1'b1;
    out_ready_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if ($urandom_range(0, 63) == 0) rx_bursty = !rx_bursty;
      if (hold_off_req) begin
        // A long stall keeps a result waiting so that the block holds off the next item.
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (!calm && rx_bursty && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    verdict_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_verdicts.size() == 0) begin
        $display("%0t: unexpected result, expected none, got success %0b status %0d count %0d",
                 $time, success_o, status_o, entry_count_o);
        errors++;
      end else begin
        want = pending_verdicts.pop_front();
        if (success_o !== want.success) begin
          $display("%0t: success expected %0b, got %0b", $time, want.success, success_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status expected %0d, got %0d", $time, want.status, status_o);
          errors++;
        end
        if (entry_count_o !== want.count) begin
          $display("%0t: entry_count expected %0d, got %0d", $time, want.count,
                   entry_count_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_sorted_multiset_table: done, errors");
      $finish;
    end
  end

endmodule

/* sim.f */
rtl/smt_pkg.sv
rtl/smt_cmp.sv
rtl/sorted_multiset_table.sv
rtl/smt_checker.sv
verif/tb_sorted_multiset_table.sv
